>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the page frame pool checkers. Every macro samples
// on the rising edge of clk and is switched off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold at that edge.
`define PFPM_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication: when ante holds, cons must hold at the next edge.
`define PFPM_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/pfpm_pkg.sv
// ----------------------------------------------------------------------------
// pfpm_pkg
// Shared types, codes and constants of the page frame pool manager.
// ----------------------------------------------------------------------------
package pfpm_pkg;

	// Default sizing
	localparam int FRAME_SLOTS_DEF = 256;
	localparam int OWNER_BITS_DEF  = 8;

	// Fixed field widths
	localparam int FRAME_W = 8;
	localparam int OP_W    = 3;
	localparam int OWNER_W = 8;
	localparam int CFG_W   = 9;
	localparam int CNT_W   = 9;
	localparam int IN_W    = 24;
	localparam int OUT_W   = 40;

	// Frames in the pool after reset
	localparam logic [CFG_W-1:0] NUM_FRAMES_RST = 9'd256;

	// Request codes
	typedef enum logic [OP_W-1:0] {
		OP_FORMAT = 3'd0,
		OP_TAKE   = 3'd1,
		OP_RETURN = 3'd2,
		OP_ADD    = 3'd3,
		OP_POP    = 3'd4,
		OP_REMOVE = 3'd5
	} op_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_FULL     = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	// Controller states
	typedef enum logic [3:0] {
		S_IDLE,
		S_EXEC,
		S_TAKE_WAIT,
		S_POP_WAIT,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_SHIFT_RD,
		S_SHIFT_WR,
		S_OUT
	} state_t;

	// Source of the pending result's frame and owner
	typedef enum logic [1:0] {
		RES_NONE,
		RES_STAT,
		RES_FREE,
		RES_VICTIM
	} res_sel_t;

	// Controller to datapath commands
	typedef struct packed {
		logic     in_load;
		logic     fs_format;
		logic     fs_pop;
		logic     fs_push;
		logic     uq_add;
		logic     uq_pop_rd;
		logic     uq_pop;
		logic     uq_dec;
		logic     scan_init;
		logic     scan_rd;
		logic     scan_next;
		logic     mark;
		logic     shift_wr;
		logic     out_load;
		res_sel_t res_sel;
		status_t  res_status;
	} dp_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic fmt_zero;
		logic free_empty;
		logic free_full;
		logic used_empty;
		logic used_full;
		logic scan_end;
		logic match;
		logic out_free;
	} dp_stat_t;

endpackage

>>> rtl/pfpm_ctrl.sv
// ----------------------------------------------------------------------------
// pfpm_ctrl
// Request sequencer: takes one request at a time, steps the datapath through
// it and hands the result to the output register.
// ----------------------------------------------------------------------------
module pfpm_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [pfpm_pkg::OP_W-1:0]   in_op,
	input  pfpm_pkg::dp_stat_t          stat,
	output pfpm_pkg::dp_cmd_t           cmd
);

	pfpm_pkg::state_t state_q, state_d;
	pfpm_pkg::op_t    op_q;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pfpm_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Latched request code
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= pfpm_pkg::OP_FORMAT;
		end else if (cmd.in_load) begin
			op_q <= pfpm_pkg::op_t'(in_op);
		end
	end

	// Next state and commands
	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		cmd.res_sel    = pfpm_pkg::RES_NONE;
		cmd.res_status = pfpm_pkg::ST_OK;
		in_ready       = 1'b0;
		unique case (state_q)
			pfpm_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.in_load = 1'b1;
					state_d     = pfpm_pkg::S_EXEC;
				end
			end
			pfpm_pkg::S_EXEC: begin
				state_d     = pfpm_pkg::S_OUT;
				cmd.res_sel = pfpm_pkg::RES_STAT;
				unique case (op_q)
					pfpm_pkg::OP_FORMAT: begin
						if (stat.fmt_zero) begin
							cmd.res_status = pfpm_pkg::ST_EMPTY;
						end else begin
							cmd.fs_format = 1'b1;
						end
					end
					pfpm_pkg::OP_TAKE: begin
						if (stat.free_empty) begin
							cmd.res_status = pfpm_pkg::ST_EMPTY;
						end else begin
							cmd.res_sel = pfpm_pkg::RES_NONE;
							cmd.fs_pop  = 1'b1;
							state_d     = pfpm_pkg::S_TAKE_WAIT;
						end
					end
					pfpm_pkg::OP_RETURN: begin
						if (stat.free_full) begin
							cmd.res_status = pfpm_pkg::ST_FULL;
						end else begin
							cmd.fs_push = 1'b1;
						end
					end
					pfpm_pkg::OP_ADD: begin
						if (stat.used_full) begin
							cmd.res_status = pfpm_pkg::ST_FULL;
						end else begin
							cmd.uq_add = 1'b1;
						end
					end
					pfpm_pkg::OP_POP: begin
						if (stat.used_empty) begin
							cmd.res_status = pfpm_pkg::ST_EMPTY;
						end else begin
							cmd.res_sel   = pfpm_pkg::RES_NONE;
							cmd.uq_pop_rd = 1'b1;
							state_d       = pfpm_pkg::S_POP_WAIT;
						end
					end
					pfpm_pkg::OP_REMOVE: begin
						cmd.res_sel   = pfpm_pkg::RES_NONE;
						cmd.scan_init = 1'b1;
						state_d       = pfpm_pkg::S_SCAN_RD;
					end
					default: begin
						// unused codes: no change, status ok
						cmd.res_status = pfpm_pkg::ST_OK;
					end
				endcase
			end
			pfpm_pkg::S_TAKE_WAIT: begin
				cmd.res_sel = pfpm_pkg::RES_FREE;
				state_d     = pfpm_pkg::S_OUT;
			end
			pfpm_pkg::S_POP_WAIT: begin
				cmd.res_sel = pfpm_pkg::RES_VICTIM;
				cmd.uq_pop  = 1'b1;
				state_d     = pfpm_pkg::S_OUT;
			end
			// search: one read, one compare per entry
			pfpm_pkg::S_SCAN_RD: begin
				if (stat.scan_end) begin
					cmd.res_sel    = pfpm_pkg::RES_STAT;
					cmd.res_status = pfpm_pkg::ST_NOTFOUND;
					state_d        = pfpm_pkg::S_OUT;
				end else begin
					cmd.scan_rd = 1'b1;
					state_d     = pfpm_pkg::S_SCAN_CMP;
				end
			end
			pfpm_pkg::S_SCAN_CMP: begin
				cmd.scan_next = 1'b1;
				if (stat.match) begin
					cmd.mark = 1'b1;
					state_d  = pfpm_pkg::S_SHIFT_RD;
				end else begin
					state_d = pfpm_pkg::S_SCAN_RD;
				end
			end
			// compaction: move each later entry down by one place
			pfpm_pkg::S_SHIFT_RD: begin
				if (stat.scan_end) begin
					cmd.uq_dec     = 1'b1;
					cmd.res_sel    = pfpm_pkg::RES_STAT;
					cmd.res_status = pfpm_pkg::ST_OK;
					state_d        = pfpm_pkg::S_OUT;
				end else begin
					cmd.scan_rd = 1'b1;
					state_d     = pfpm_pkg::S_SHIFT_WR;
				end
			end
			pfpm_pkg::S_SHIFT_WR: begin
				cmd.shift_wr  = 1'b1;
				cmd.scan_next = 1'b1;
				state_d       = pfpm_pkg::S_SHIFT_RD;
			end
			pfpm_pkg::S_OUT: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = pfpm_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = pfpm_pkg::S_IDLE;
			end
		endcase
	end

endmodule

>>> rtl/pfpm_datapath.sv
// ----------------------------------------------------------------------------
// pfpm_datapath
// Free frame stack, used frame queue, request and result registers. Acts only
// on commands from the sequencer and reports its conditions back.
// ----------------------------------------------------------------------------
module pfpm_datapath #(
	parameter int FRAME_SLOTS = pfpm_pkg::FRAME_SLOTS_DEF,
	parameter int OWNER_BITS  = pfpm_pkg::OWNER_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [pfpm_pkg::CFG_W-1:0]    cfg_data,
	input  logic [pfpm_pkg::FRAME_W-1:0]  in_frame,
	input  logic [pfpm_pkg::OWNER_W-1:0]  in_owner,
	input  pfpm_pkg::dp_cmd_t             cmd,
	output pfpm_pkg::dp_stat_t            stat,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [pfpm_pkg::OUT_W-1:0]    m_tdata
);

	localparam int AW    = $clog2(FRAME_SLOTS);
	localparam int AW1   = AW + 1;
	localparam int DW    = $clog2(FRAME_SLOTS + 1);
	localparam int FW    = pfpm_pkg::FRAME_W;
	localparam int QW    = OWNER_BITS + FW;
	localparam int CLAMP = (FRAME_SLOTS < 256) ? FRAME_SLOTS : 256;
	localparam int PAD_W = pfpm_pkg::OUT_W - 2 - 2 * FW - 2 * pfpm_pkg::CNT_W;

	localparam logic [DW-1:0]  SLOTS_D = DW'(FRAME_SLOTS);
	localparam logic [DW-1:0]  CLAMP_D = DW'(CLAMP);
	localparam logic [AW1-1:0] SLOTS_W = AW1'(FRAME_SLOTS);
	localparam logic [AW-1:0]  LAST_A  = AW'(FRAME_SLOTS - 1);

	// Circular pointer step
	function automatic logic [AW-1:0] inc_wrap(input logic [AW-1:0] ptr);
		inc_wrap = (ptr == LAST_A) ? '0 : ptr + AW'(1);
	endfunction

	// ------------------------------------------------------------------
	// Configuration register
	// ------------------------------------------------------------------
	logic [pfpm_pkg::CFG_W-1:0] num_frames_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_frames_q <= pfpm_pkg::NUM_FRAMES_RST;
		end else if (cfg_valid) begin
			num_frames_q <= cfg_data;
		end
	end

	// Frame count for format, clamped to the pool and to 8-bit frame numbers
	logic [pfpm_pkg::CFG_W-1:0] fmt_n9;
	logic [DW-1:0]              fmt_n;

	assign fmt_n9 = (num_frames_q > pfpm_pkg::CFG_W'(CLAMP)) ? pfpm_pkg::CFG_W'(CLAMP)
	                                                          : num_frames_q;
	assign fmt_n  = DW'(fmt_n9);

	// ------------------------------------------------------------------
	// Request registers
	// ------------------------------------------------------------------
	logic [FW-1:0]         frame_q;
	logic [OWNER_BITS-1:0] owner_q;

	always_ff @(posedge clk) begin
		if (cmd.in_load) begin
			frame_q <= in_frame;
			owner_q <= OWNER_BITS'(in_owner);
		end
	end

	// ------------------------------------------------------------------
	// Free stack: entries below fs_lim_q that were not pushed since the
	// last format hold their formatted value, fs_fmtn_q - 1 - index.
	// ------------------------------------------------------------------
	logic [FW-1:0] fs_mem [FRAME_SLOTS];
	logic [DW-1:0] fs_depth_q, fs_lim_q, fs_fmtn_q;
	logic [DW-1:0] fs_top;
	logic [FW-1:0] fs_rdata_q, fs_fval_q;
	logic          fs_hit_q;

	assign fs_top = fs_depth_q - DW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fs_depth_q <= CLAMP_D;
			fs_lim_q   <= CLAMP_D;
			fs_fmtn_q  <= CLAMP_D;
		end else if (cmd.fs_format) begin
			fs_depth_q <= fmt_n;
			fs_lim_q   <= fmt_n;
			fs_fmtn_q  <= fmt_n;
		end else if (cmd.fs_pop) begin
			fs_depth_q <= fs_top;
		end else if (cmd.fs_push) begin
			fs_depth_q <= fs_depth_q + DW'(1);
			if (fs_depth_q < fs_lim_q) begin
				fs_lim_q <= fs_depth_q;
			end
		end
	end

	// Stack memory port and pop capture
	always_ff @(posedge clk) begin
		if (cmd.fs_push) begin
			fs_mem[fs_depth_q[AW-1:0]] <= frame_q;
		end
		if (cmd.fs_pop) begin
			fs_rdata_q <= fs_mem[fs_top[AW-1:0]];
			fs_hit_q   <= (fs_top < fs_lim_q);
			fs_fval_q  <= FW'(fs_fmtn_q - fs_depth_q);
		end
	end

	// ------------------------------------------------------------------
	// Used queue: circular buffer of {owner, frame}
	// ------------------------------------------------------------------
	logic [QW-1:0]  uq_mem [FRAME_SLOTS];
	logic [QW-1:0]  uq_rdata_q;
	logic [AW-1:0]  head_q, rd_ptr_q, wr_ptr_q;
	logic [DW-1:0]  ud_q, idx_q;
	logic [AW1-1:0] tail_sum;
	logic [AW-1:0]  tail;
	logic           uq_we, uq_re;
	logic [AW-1:0]  uq_wa, uq_ra;
	logic [QW-1:0]  uq_wd;

	assign tail_sum = AW1'(head_q) + AW1'(ud_q);
	assign tail     = (tail_sum >= SLOTS_W) ? AW'(tail_sum - SLOTS_W) : tail_sum[AW-1:0];

	assign uq_we = cmd.uq_add | cmd.shift_wr;
	assign uq_wa = cmd.uq_add ? tail : wr_ptr_q;
	assign uq_wd = cmd.uq_add ? {owner_q, frame_q} : uq_rdata_q;
	assign uq_re = cmd.uq_pop_rd | cmd.scan_rd;
	assign uq_ra = cmd.uq_pop_rd ? head_q : rd_ptr_q;

	// Queue memory port
	always_ff @(posedge clk) begin
		if (uq_we) begin
			uq_mem[uq_wa] <= uq_wd;
		end
		if (uq_re) begin
			uq_rdata_q <= uq_mem[uq_ra];
		end
	end

	// Head and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			ud_q   <= '0;
		end else begin
			if (cmd.uq_pop) begin
				head_q <= inc_wrap(head_q);
			end
			if (cmd.uq_add) begin
				ud_q <= ud_q + DW'(1);
			end else if (cmd.uq_pop || cmd.uq_dec) begin
				ud_q <= ud_q - DW'(1);
			end
		end
	end

	// Search and compaction pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
		end else begin
			if (cmd.scan_init) begin
				idx_q    <= '0;
				rd_ptr_q <= head_q;
			end else if (cmd.scan_next) begin
				idx_q    <= idx_q + DW'(1);
				rd_ptr_q <= inc_wrap(rd_ptr_q);
			end
			if (cmd.mark || cmd.shift_wr) begin
				wr_ptr_q <= rd_ptr_q;
			end
		end
	end

	// ------------------------------------------------------------------
	// Pending result
	// ------------------------------------------------------------------
	pfpm_pkg::status_t res_status_q;
	logic [FW-1:0]     res_frame_q;
	logic [FW-1:0]     res_owner_q;

	always_ff @(posedge clk) begin
		case (cmd.res_sel)
			pfpm_pkg::RES_STAT: begin
				res_status_q <= cmd.res_status;
				res_frame_q  <= '0;
				res_owner_q  <= '0;
			end
			pfpm_pkg::RES_FREE: begin
				res_status_q <= pfpm_pkg::ST_OK;
				res_frame_q  <= fs_hit_q ? fs_fval_q : fs_rdata_q;
				res_owner_q  <= '0;
			end
			pfpm_pkg::RES_VICTIM: begin
				res_status_q <= pfpm_pkg::ST_OK;
				res_frame_q  <= uq_rdata_q[FW-1:0];
				res_owner_q  <= FW'(uq_rdata_q[QW-1:FW]);
			end
			default: begin
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Output register
	// ------------------------------------------------------------------
	logic                        out_valid_q;
	pfpm_pkg::status_t           out_status_q;
	logic [FW-1:0]               out_frame_q, out_owner_q;
	logic [pfpm_pkg::CNT_W-1:0]  out_free_q, out_used_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_status_q <= res_status_q;
			out_frame_q  <= res_frame_q;
			out_owner_q  <= res_owner_q;
			out_free_q   <= pfpm_pkg::CNT_W'(fs_depth_q);
			out_used_q   <= pfpm_pkg::CNT_W'(ud_q);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{PAD_W{1'b0}}, out_used_q, out_free_q, out_owner_q, out_frame_q,
	                   out_status_q};

	// ------------------------------------------------------------------
	// Status to the sequencer
	// ------------------------------------------------------------------
	assign stat.fmt_zero   = (num_frames_q == '0);
	assign stat.free_empty = (fs_depth_q == '0);
	assign stat.free_full  = (fs_depth_q == SLOTS_D);
	assign stat.used_empty = (ud_q == '0);
	assign stat.used_full  = (ud_q == SLOTS_D);
	assign stat.scan_end   = (idx_q == ud_q);
	assign stat.match      = (uq_rdata_q[FW-1:0] == frame_q);
	assign stat.out_free   = !out_valid_q || m_tready;

endmodule

>>> rtl/page_frame_pool_manager.sv
// Page frame pool manager. Serves one request at a time and returns one result
// per request. Format, return, add, the unused codes and a failed take or pop
// victim go from the execute state to the output state; a successful take or
// pop victim passes a wait state for the registered read of the stack or queue
// memory. Remove walks the used queue through its single read port, a read and
// a compare state per entry up to the match, then a read and a write state per
// later entry, so every entry is visited whether or not one matches. A new
// request is taken the cycle after the result is loaded into the output
// register, even while that result still waits to be taken. No clearing pass
// runs after reset: the free stack's formatted contents are tracked by a
// watermark, and used queue entries are only read below the fill count.
// ----------------------------------------------------------------------------
// page_frame_pool_manager
// Top level: sequencer plus free stack / used queue datapath.
// ----------------------------------------------------------------------------
module page_frame_pool_manager #(
	parameter int FRAME_SLOTS = pfpm_pkg::FRAME_SLOTS_DEF,
	parameter int OWNER_BITS  = pfpm_pkg::OWNER_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration write: num_frames
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [pfpm_pkg::CFG_W-1:0]  cfg_data,
	// requests
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [pfpm_pkg::IN_W-1:0]   s_tdata,   // operation[2:0], frame_number[10:3],
	                                               // owner_id[18:11], zero[23:19]
	// results
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [pfpm_pkg::OUT_W-1:0]  m_tdata    // status[1:0], frame_out[9:2],
	                                               // owner_out[17:10], free_count[26:18],
	                                               // used_count[35:27], zero[39:36]
);

	pfpm_pkg::dp_cmd_t  cmd;
	pfpm_pkg::dp_stat_t stat;

	// Request sequencer
	pfpm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_op    (s_tdata[2:0]),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Stores and result path
	pfpm_datapath #(
		.FRAME_SLOTS (FRAME_SLOTS),
		.OWNER_BITS  (OWNER_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_frame  (s_tdata[10:3]),
		.in_owner  (s_tdata[18:11]),
		.cmd       (cmd),
		.stat      (stat),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

>>> rtl/pfpm_checker.sv
// ----------------------------------------------------------------------------
// pfpm_checker
// Port-level checks of the page frame pool manager, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pfpm_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_tvalid,
	input logic                        s_tready,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [pfpm_pkg::OUT_W-1:0]  m_tdata
);

	// A stalled result holds its value
	`PFPM_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

	// One request at a time: the input closes right after a transaction
	`PFPM_ASSERT_NXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "request taken while busy")

	// A failed request reports no frame and no owner
	`PFPM_ASSERT_IMP(a_fail_zero, m_tvalid && (m_tdata[1:0] != pfpm_pkg::ST_OK), m_tdata[17:2] == 16'd0, "nonzero frame or owner on failure")

endmodule

bind page_frame_pool_manager pfpm_checker u_pfpm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
